@@ rtl/ircbt_pkg.sv @@
// Package for the IR code binding table: status and operation codes,
// controller states and the table entry layout.
// No dependencies.
package ircbt_pkg;

  localparam int unsigned MaxSlotsDef   = 32;
  localparam int unsigned ProtoW        = 8;
  localparam int unsigned ValueW        = 64;
  localparam int unsigned BitsW         = 8;
  localparam int unsigned ActionW       = 4;
  localparam int unsigned TimeW         = 32;
  localparam int unsigned DebounceW     = 16;
  localparam int unsigned SlotOutW      = 8;
  localparam int unsigned UsedOutW      = 9;

  localparam logic [DebounceW-1:0] DebounceReset = 16'd400;
  localparam logic [ActionW-1:0]   ActionNone    = 4'd0;
  localparam logic [ActionW-1:0]   ActionLast    = 4'd10;

  // operation codes
  localparam logic [1:0] KindPress  = 2'd0;
  localparam logic [1:0] KindBind   = 2'd1;
  localparam logic [1:0] KindRemove = 2'd2;
  localparam logic [1:0] KindClear  = 2'd3;

  // result status codes
  localparam logic [3:0] StNoMatch  = 4'd0;
  localparam logic [3:0] StRepeat   = 4'd1;
  localparam logic [3:0] StTooSoon  = 4'd2;
  localparam logic [3:0] StAct      = 4'd3;
  localparam logic [3:0] StBound    = 4'd4;
  localparam logic [3:0] StRebound  = 4'd5;
  localparam logic [3:0] StNoAction = 4'd6;
  localparam logic [3:0] StNothing  = 4'd7;
  localparam logic [3:0] StFull     = 4'd8;
  localparam logic [3:0] StRemoved  = 4'd9;
  localparam logic [3:0] StBadIndex = 4'd10;
  localparam logic [3:0] StCleared  = 4'd11;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SRCH,
    S_SHFT,
    S_PUSH
  } state_e;

  typedef struct packed {
    logic [ProtoW-1:0]  proto;
    logic [ValueW-1:0]  value;
    logic [BitsW-1:0]   bits;
    logic [ActionW-1:0] action;
  } entry_t;

endpackage

@@ rtl/ircbt_ram.sv @@
// Entry store of the IR code binding table: one write port, one read port,
// registered read data. Depends on ircbt_pkg for the entry layout.
module ircbt_ram import ircbt_pkg::*; #(
  parameter int unsigned Depth = MaxSlotsDef,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ir_code_binding_table.sv @@
// IR code binding table, top level: controller, key search and compaction.
// Depends on ircbt_pkg and ircbt_ram.
//
// Usage: items (press, bind, remove, clear) enter on the in_ valid/ready
// channel; each produces exactly one result on the out_ valid/ready channel.
// The debounce time is written over the cfg_ channel, which is always ready;
// write it only while the block is idle.
// Operation: one item at a time. Press and bind search the entry RAM one slot a
// cycle with the read pipelined against the compare. Remove moves the entries
// above the removed slot down, one per cycle. Items that need no table access
// (repeat frame, empty table, bad action, null key, bad index, clear) go
// straight to the result. The next item is taken once the result has gone
// into the output register.
// Reset empties the table, clears the last acted value and time, and loads
// the debounce time with 400 ms; the entry RAM itself is not cleared.
// The result sits in an output register; while the receiver stalls, the next
// item is still accepted and worked on, and waits only to hand over its
// result until the register is free.
module ir_code_binding_table import ircbt_pkg::*; #(
  parameter int unsigned MAX_SLOTS = MaxSlotsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [DebounceW-1:0]  cfg_debounce_ms_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            kind_i,
  input  logic [ProtoW-1:0]     protocol_i,
  input  logic [ValueW-1:0]     code_value_i,
  input  logic [BitsW-1:0]      code_bits_i,
  input  logic                  is_repeat_i,
  input  logic [TimeW-1:0]      now_ms_i,
  input  logic [ActionW-1:0]    action_in_i,
  input  logic [SlotOutW-1:0]   slot_index_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [3:0]            status_o,
  output logic [ActionW-1:0]    action_out_o,
  output logic [SlotOutW-1:0]   slot_o,
  output logic [UsedOutW-1:0]   entries_used_o
);

  localparam int unsigned IdxW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(MAX_SLOTS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_SLOTS);

  state_e state_q, state_d;

  logic [CntW-1:0]      used_q, used_d;
  logic [CntW-1:0]      rd_cnt_q, rd_cnt_d;
  logic                 cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0]      cmp_idx_q, cmp_idx_d;
  logic [ValueW-1:0]    last_val_q, last_val_d;
  logic [TimeW-1:0]     last_time_q, last_time_d;
  logic [DebounceW-1:0] debounce_q;

  // captured item
  logic [1:0]           it_kind_q;
  entry_t               it_entry_q;
  logic [TimeW-1:0]     it_now_q;

  // pending result
  logic [3:0]           res_status_q, res_status_d;
  logic [ActionW-1:0]   res_act_q, res_act_d;
  logic [IdxW-1:0]      res_slot_q, res_slot_d;

  // output register
  logic                 out_vld_q, out_vld_d;
  logic [3:0]           out_status_q;
  logic [ActionW-1:0]   out_act_q;
  logic [IdxW-1:0]      out_slot_q;
  logic [CntW-1:0]      out_used_q;

  logic                 in_acc;
  logic                 out_free;
  logic                 issue;
  logic                 hit;
  logic                 scan_end;
  logic                 too_soon;
  logic                 act_bad;
  logic                 idx_bad;
  logic [UsedOutW-1:0]  rm_start;

  logic                 mem_we;
  logic [IdxW-1:0]      mem_waddr;
  entry_t               mem_wdata;
  entry_t               mem_rdata;

  ircbt_ram #(
    .Depth (MAX_SLOTS),
    .AddrW (IdxW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (issue),
    .raddr_i (rd_cnt_q[IdxW-1:0]),
    .rdata_o (mem_rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_vld_q || out_ready_i;

  assign issue    = ((state_q == S_SRCH) || (state_q == S_SHFT)) && (rd_cnt_q < used_q);
  assign hit      = cmp_vld_q &&
                    (mem_rdata.proto == it_entry_q.proto) &&
                    (mem_rdata.value == it_entry_q.value) &&
                    (mem_rdata.bits  == it_entry_q.bits);
  assign scan_end = !issue && !cmp_vld_q;
  assign too_soon = (it_entry_q.value == last_val_q) &&
                    ((it_now_q - last_time_q) < TimeW'(debounce_q));
  assign act_bad  = (action_in_i == ActionNone) || (action_in_i > ActionLast);
  assign idx_bad  = {1'b0, slot_index_i} >= UsedOutW'(used_q);
  assign rm_start = {1'b0, slot_index_i} + UsedOutW'(1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_PUSH;
          case (kind_i)
            KindPress: begin
              if (used_q != '0 && !is_repeat_i) begin
                state_d = S_SRCH;
              end
            end
            KindBind: begin
              if (!act_bad && !(protocol_i == '0 && code_value_i == '0)) begin
                state_d = S_SRCH;
              end
            end
            KindRemove: begin
              if (!idx_bad) begin
                state_d = S_SHFT;
              end
            end
            default: state_d = S_PUSH;
          endcase
        end
      end
      S_SRCH: begin
        if (hit || scan_end) begin
          state_d = S_PUSH;
        end
      end
      S_SHFT: begin
        if (scan_end) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    used_d       = used_q;
    rd_cnt_d     = rd_cnt_q;
    cmp_vld_d    = issue;
    cmp_idx_d    = rd_cnt_q[IdxW-1:0];
    last_val_d   = last_val_q;
    last_time_d  = last_time_q;
    res_status_d = res_status_q;
    res_act_d    = res_act_q;
    res_slot_d   = res_slot_q;
    out_vld_d    = out_vld_q;
    mem_we       = 1'b0;
    mem_waddr    = cmp_idx_q;
    mem_wdata    = it_entry_q;

    if (issue) begin
      rd_cnt_d = rd_cnt_q + CntW'(1);
    end

    case (state_q)
      S_IDLE: begin
        cmp_vld_d  = 1'b0;
        res_act_d  = ActionNone;
        res_slot_d = '0;
        rd_cnt_d   = '0;
        if (in_acc) begin
          case (kind_i)
            KindPress: begin
              res_status_d = (used_q == '0) ? StNoMatch : StRepeat;
            end
            KindBind: begin
              res_status_d = act_bad ? StNoAction : StNothing;
            end
            KindRemove: begin
              res_status_d = StBadIndex;
              if (!idx_bad) begin
                rd_cnt_d = rm_start[CntW-1:0];
              end
            end
            default: begin
              res_status_d = StCleared;
              used_d       = '0;
            end
          endcase
        end
      end
      S_SRCH: begin
        if (it_kind_q == KindPress) begin
          if (hit) begin
            res_slot_d = cmp_idx_q;
            if (too_soon) begin
              res_status_d = StTooSoon;
            end else begin
              res_status_d = StAct;
              res_act_d    = mem_rdata.action;
              last_val_d   = it_entry_q.value;
              last_time_d  = it_now_q;
            end
          end else if (scan_end) begin
            res_status_d = StNoMatch;
          end
        end else begin
          if (hit) begin
            // same key: rewrite the entry with the new action
            mem_we       = 1'b1;
            res_slot_d   = cmp_idx_q;
            res_status_d = StRebound;
          end else if (scan_end) begin
            if (used_q < MaxCnt) begin
              mem_we       = 1'b1;
              mem_waddr    = used_q[IdxW-1:0];
              res_slot_d   = used_q[IdxW-1:0];
              res_status_d = StBound;
              used_d       = used_q + CntW'(1);
            end else begin
              res_status_d = StFull;
            end
          end
        end
      end
      S_SHFT: begin
        // entry read from slot n lands in slot n-1
        if (cmp_vld_q) begin
          mem_we    = 1'b1;
          mem_waddr = cmp_idx_q - IdxW'(1);
          mem_wdata = mem_rdata;
        end
        if (scan_end) begin
          used_d       = used_q - CntW'(1);
          res_status_d = StRemoved;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          out_vld_d = 1'b1;
        end
      end
      default: begin
        cmp_vld_d = 1'b0;
      end
    endcase

    if (out_vld_q && out_ready_i && !(state_q == S_PUSH)) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      rd_cnt_q    <= '0;
      cmp_vld_q   <= 1'b0;
      last_val_q  <= '0;
      last_time_q <= '0;
      debounce_q  <= DebounceReset;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      rd_cnt_q    <= rd_cnt_d;
      cmp_vld_q   <= cmp_vld_d;
      last_val_q  <= last_val_d;
      last_time_q <= last_time_d;
      out_vld_q   <= out_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        debounce_q <= cfg_debounce_ms_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q    <= cmp_idx_d;
    res_status_q <= res_status_d;
    res_act_q    <= res_act_d;
    res_slot_q   <= res_slot_d;
    if (in_acc) begin
      it_kind_q         <= kind_i;
      it_entry_q.proto  <= protocol_i;
      it_entry_q.value  <= code_value_i;
      it_entry_q.bits   <= code_bits_i;
      it_entry_q.action <= action_in_i;
      it_now_q          <= now_ms_i;
    end
    if (state_q == S_PUSH && out_free) begin
      out_status_q <= res_status_q;
      out_act_q    <= res_act_q;
      out_slot_q   <= res_slot_q;
      out_used_q   <= used_q;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign status_o       = out_status_q;
  assign action_out_o   = out_act_q;
  assign slot_o         = SlotOutW'(out_slot_q);
  assign entries_used_o = UsedOutW'(out_used_q);

endmodule
